/* hdl/usbeds_pkg.sv */
// Package for the USB endpoint descriptor scanner.
// Holds the transfer payload types, the match phase type and the descriptor codes.
// No dependencies.
package usbeds_pkg;

    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0] DESC_TYPE_COMPANION = 8'h30;
    localparam logic [7:0] MIN_DESC_LENGTH     = 8'd2;
    localparam logic [7:0] MIN_IFC_LENGTH      = 8'd4;
    localparam logic [7:0] MIN_EP_LENGTH       = 8'd7;
    localparam logic [7:0] MIN_CMP_LENGTH      = 8'd6;
    localparam logic [1:0] XFER_TYPE_INTERRUPT = 2'b11;

    // Byte positions inside a descriptor.
    localparam logic [7:0] OFS_LENGTH  = 8'd0;
    localparam logic [7:0] OFS_TYPE    = 8'd1;
    localparam logic [7:0] OFS_BYTE2   = 8'd2;
    localparam logic [7:0] OFS_BYTE3   = 8'd3;
    localparam logic [7:0] OFS_BYTE4   = 8'd4;
    localparam logic [7:0] OFS_BYTE5   = 8'd5;
    localparam logic [7:0] OFS_BYTE6   = 8'd6;

    typedef enum logic [1:0] {
        PH_SEARCH    = 2'd0,
        PH_COMPANION = 2'd1,
        PH_DONE      = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic        is_interrupt;
        logic [7:0]  poll_interval;
        logic        ifc_present;
        logic [7:0]  ifc_number;
        logic [7:0]  ifc_alt;
        logic        cmp_present;
        logic [7:0]  cmp_burst;
        logic [15:0] cmp_bytes;
    } t_out_item;

endpackage

/* hdl/usb_endpoint_descriptor_scanner_top.sv */
// Top level of the USB endpoint descriptor scanner.
// Walks a configuration descriptor blob byte by byte; depends on usbeds_pkg.
//
//   channel | direction | handshake           | payload
//   in      | input     | i_in_valid/o_in_stall   | i_in_data  (t_in_item)
//   out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (endpoint address)
//
// One byte is taken per cycle; each byte passes through one level of compare and
// select logic into the parse registers. The result of a blob appears in the output
// register on the cycle after its last byte is taken. Input stalls only while a result
// sits in the output register and the output side stalls. Reset is synchronous and
// clears the parse state, the output valid flag and the endpoint address.
module usb_endpoint_descriptor_scanner_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  usbeds_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output usbeds_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);
    import usbeds_pkg::*;

    logic [7:0] r_ep_addr;
    logic [7:0] r_offset, n_offset;
    logic [7:0] r_length, n_length;
    logic [7:0] r_type, n_type;
    logic [7:0] r_cap0, n_cap0;
    logic [7:0] r_cap1, n_cap1;
    logic [7:0] r_cap2, n_cap2;
    logic       r_ifc_valid, n_ifc_valid;
    logic [7:0] r_ifc_num, n_ifc_num;
    logic [7:0] r_ifc_alt, n_ifc_alt;
    logic       r_halted, n_halted;
    t_phase     r_phase, n_phase;
    t_out_item  r_hold, n_hold;
    t_out_item  w_result;
    logic       r_out_valid;
    t_out_item  r_out_data;

    logic w_accept;
    logic w_ep_hit;
    logic w_cmp_end;
    logic w_desc_done;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Parse datapath.
    always_comb begin
        n_offset    = r_offset;
        n_length    = r_length;
        n_type      = r_type;
        n_cap0      = r_cap0;
        n_cap1      = r_cap1;
        n_cap2      = r_cap2;
        n_ifc_valid = r_ifc_valid;
        n_ifc_num   = r_ifc_num;
        n_ifc_alt   = r_ifc_alt;
        n_halted    = r_halted;
        w_result    = r_hold;
        w_ep_hit    = 1'b0;
        w_cmp_end   = 1'b0;
        w_desc_done = 1'b0;

        if (w_accept && r_phase == PH_SEARCH && !r_halted) begin
            unique case (r_offset)
                OFS_LENGTH: begin
                    if (i_in_data.data_byte < MIN_DESC_LENGTH) begin
                        n_halted = 1'b1;
                    end else begin
                        n_length = i_in_data.data_byte;
                    end
                end
                OFS_TYPE:  n_type = i_in_data.data_byte;
                OFS_BYTE2: n_cap0 = i_in_data.data_byte;
                OFS_BYTE3: n_cap1 = i_in_data.data_byte;
                OFS_BYTE6: n_cap2 = i_in_data.data_byte;
                default:   ;
            endcase
            if (!(r_offset == OFS_LENGTH && i_in_data.data_byte < MIN_DESC_LENGTH)) begin
                if (r_offset != OFS_LENGTH && r_offset == r_length - 8'd1) begin
                    n_offset    = '0;
                    w_desc_done = 1'b1;
                end else begin
                    n_offset = r_offset + 8'd1;
                end
            end
            if (w_desc_done) begin
                // The endpoint takes the interface context from before this descriptor.
                if (n_type == DESC_TYPE_ENDPOINT && n_length >= MIN_EP_LENGTH
                        && n_cap0 == r_ep_addr) begin
                    w_ep_hit               = 1'b1;
                    w_result               = '0;
                    w_result.found         = 1'b1;
                    w_result.is_interrupt  = (n_cap1[1:0] == XFER_TYPE_INTERRUPT);
                    w_result.poll_interval = n_cap2;
                    w_result.ifc_present   = r_ifc_valid;
                    w_result.ifc_number    = r_ifc_num;
                    w_result.ifc_alt       = r_ifc_alt;
                end
                if (n_type == DESC_TYPE_INTERFACE && n_length >= MIN_IFC_LENGTH) begin
                    n_ifc_valid = 1'b1;
                    n_ifc_num   = n_cap0;
                    n_ifc_alt   = n_cap1;
                end
            end
        end else if (w_accept && r_phase == PH_COMPANION) begin
            unique case (r_offset)
                OFS_LENGTH: n_length = i_in_data.data_byte;
                OFS_TYPE:   n_type   = i_in_data.data_byte;
                OFS_BYTE2:  n_cap0   = i_in_data.data_byte;
                OFS_BYTE4:  n_cap1   = i_in_data.data_byte;
                OFS_BYTE5: begin
                    w_cmp_end = 1'b1;
                    if (r_length >= MIN_CMP_LENGTH && r_type == DESC_TYPE_COMPANION) begin
                        w_result.cmp_present = 1'b1;
                        w_result.cmp_burst   = r_cap0;
                        w_result.cmp_bytes   = {i_in_data.data_byte, r_cap1};
                    end
                end
                default: ;
            endcase
            n_offset = r_offset + 8'd1;
        end

        n_hold = w_result;

        // A finished blob returns the parser to its reset state.
        if (w_accept && i_in_data.last_byte) begin
            n_offset    = '0;
            n_length    = '0;
            n_type      = '0;
            n_cap0      = '0;
            n_cap1      = '0;
            n_cap2      = '0;
            n_ifc_valid = 1'b0;
            n_ifc_num   = '0;
            n_ifc_alt   = '0;
            n_halted    = 1'b0;
            n_hold      = '0;
        end
    end

    // Match phase next state.
    always_comb begin
        n_phase = r_phase;
        if (w_accept && i_in_data.last_byte) begin
            n_phase = PH_SEARCH;
        end else if (w_ep_hit) begin
            n_phase = PH_COMPANION;
        end else if (w_cmp_end) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep_addr   <= '0;
            r_offset    <= '0;
            r_length    <= '0;
            r_type      <= '0;
            r_cap0      <= '0;
            r_cap1      <= '0;
            r_cap2      <= '0;
            r_ifc_valid <= 1'b0;
            r_ifc_num   <= '0;
            r_ifc_alt   <= '0;
            r_halted    <= 1'b0;
            r_phase     <= PH_SEARCH;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ep_addr <= i_cfg_data;
            end
            r_offset    <= n_offset;
            r_length    <= n_length;
            r_type      <= n_type;
            r_cap0      <= n_cap0;
            r_cap1      <= n_cap1;
            r_cap2      <= n_cap2;
            r_ifc_valid <= n_ifc_valid;
            r_ifc_num   <= n_ifc_num;
            r_ifc_alt   <= n_ifc_alt;
            r_halted    <= n_halted;
            r_phase     <= n_phase;
            r_hold      <= n_hold;
            if (w_accept && i_in_data.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result register holds its contents while the output transfer is stalled.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.last_byte) begin
            r_out_data <= w_result;
        end
    end

endmodule
